### rtl/murmur2_hash_engine_core_assert.svh
// Assertion macros for the MurmurHash2 engine.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef MURMUR2_HASH_ENGINE_CORE_ASSERT_SVH
`define MURMUR2_HASH_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define MM2_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mm2 assertion failed");

// Next-cycle implication, disabled in reset.
`define MM2_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mm2 assertion failed");

`endif

### rtl/mm2_pkg.sv
// Shared types, constants and helpers for the MurmurHash2 engine.
// No dependencies.
package mm2_pkg;

  localparam logic [31:0] MIX_MUL      = 32'h5bd1e995;
  localparam int          MIX_SHIFT    = 24;
  localparam int          AVAL_SHIFT_A = 13;
  localparam int          AVAL_SHIFT_B = 15;
  localparam logic [2:0]  FULL_BYTES   = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_K1,
    ST_K2,
    ST_HMIX,
    ST_TAIL,
    ST_AVAL
  } mm2_state_t;

  // Sequencer to datapath
  typedef struct packed {
    logic       ready;
    logic       accept;
    logic       aval_fire;
    mm2_state_t op;
  } mm2_ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic       in_valid;
    logic       in_last;
    logic [2:0] in_nbytes;
    logic       item_last;
    logic       out_block;
  } mm2_stat_t;

  function automatic logic [2:0] sat_bytes(input logic [2:0] nb);
    sat_bytes = (nb > FULL_BYTES) ? FULL_BYTES : nb;
  endfunction

  function automatic logic [31:0] tail_mask(input logic [1:0] nb);
    logic [31:0] m;
    unique case (nb)
      2'd1:    m = 32'h0000_00ff;
      2'd2:    m = 32'h0000_ffff;
      2'd3:    m = 32'h00ff_ffff;
      default: m = 32'hffff_ffff;
    endcase
    tail_mask = m;
  endfunction

endpackage

### rtl/mm2_mul.sv
// Shared multiply-by-constant unit (low 32 bits of a * MIX_MUL).
// Depends on mm2_pkg.
module mm2_mul
  import mm2_pkg::*;
(
  input  logic [31:0] mul_a,
  output logic [31:0] mul_p
);

  assign mul_p = mul_a * MIX_MUL;

endmodule

### rtl/mm2_seq.sv
// Step sequencer for the MurmurHash2 engine.
// Depends on mm2_pkg.
module mm2_seq
  import mm2_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  mm2_stat_t stat,
  output mm2_ctrl_t ctrl
);

  mm2_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    ctrl.ready     = 1'b0;
    ctrl.accept    = 1'b0;
    ctrl.aval_fire = 1'b0;
    ctrl.op        = state_r;
    unique case (state_r)
      ST_IDLE: begin
        ctrl.ready = 1'b1;
        if (stat.in_valid) begin
          ctrl.accept = 1'b1;
          priority if (!stat.in_last || stat.in_nbytes == FULL_BYTES) begin
            state_nxt = ST_K1;
          end else if (stat.in_nbytes == 3'd0) begin
            state_nxt = ST_AVAL;
          end else begin
            state_nxt = ST_TAIL;
          end
        end
      end
      ST_K1:   state_nxt = ST_K2;
      ST_K2:   state_nxt = ST_HMIX;
      ST_HMIX: state_nxt = stat.item_last ? ST_AVAL : ST_IDLE;
      ST_TAIL: state_nxt = ST_AVAL;
      ST_AVAL: begin
        // hold until the output register is free
        if (!stat.out_block) begin
          ctrl.aval_fire = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

### rtl/murmur2_hash_engine_core.sv
// Top level of the streaming MurmurHash2 (32-bit) engine.
// Depends on mm2_pkg, mm2_mul, mm2_seq and murmur2_hash_engine_core_assert.svh.
//
// Channel   Direction  Handshake           Payload
// in_       input      in_valid/in_stall   first_word seed total_len data_word
//                                          bytes_valid last_word
// out_      output     out_valid/out_stall hash_value
//
// Steps per item: non-last word idle, K1, K2, HMIX; last full word adds AVAL;
// 1..3 tail bytes idle, TAIL, AVAL; none idle, AVAL. AVAL waits while a result is held.
// Each mixing step uses the one shared 32-bit multiplier, one multiply a cycle.
// Reset (synchronous, rst_n low) returns to idle, clears the running hash and
// drops any pending result. in_stall is high whenever the sequencer is busy.
// A stalled result waits in the output register; the next item is taken meanwhile.
module murmur2_hash_engine_core
  import mm2_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_first_word,
  input  logic [31:0] in_seed,
  input  logic [31:0] in_total_len,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_bytes_valid,
  input  logic        in_last_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_hash_value
);

  mm2_ctrl_t ctrl;
  mm2_stat_t stat;

  // running hash, mixed key, captured word and item flags
  logic [31:0] h_r, h_nxt;
  logic [31:0] k_r, k_nxt;
  logic [31:0] w_r, w_nxt;
  logic [1:0]  nb_r, nb_nxt;
  logic        last_r, last_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_hash_r, out_hash_nxt;

  logic [31:0] mul_a, mul_p;
  logic [2:0]  in_nb_sat;

  assign in_nb_sat = sat_bytes(in_bytes_valid);

  assign stat.in_valid  = in_valid;
  assign stat.in_last   = in_last_word;
  assign stat.in_nbytes = in_nb_sat;
  assign stat.item_last = last_r;
  assign stat.out_block = out_valid_r & out_stall;

  mm2_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // Pick the multiplier operand for the current step
  always_comb begin
    unique case (ctrl.op)
      ST_K1:   mul_a = w_r;
      ST_K2:   mul_a = k_r;
      ST_HMIX: mul_a = h_r;
      ST_TAIL: mul_a = h_r ^ (w_r & tail_mask(nb_r));
      ST_AVAL: mul_a = h_r ^ (h_r >> AVAL_SHIFT_A);
      default: mul_a = w_r;
    endcase
  end

  mm2_mul u_mul (
    .mul_a (mul_a),
    .mul_p (mul_p)
  );

  always_comb begin
    h_nxt         = h_r;
    k_nxt         = k_r;
    w_nxt         = w_r;
    nb_nxt        = nb_r;
    last_nxt      = last_r;
    out_hash_nxt  = out_hash_r;
    out_valid_nxt = out_valid_r & out_stall;   // drop once taken

    if (ctrl.accept) begin
      // first item of a message loads seed XOR length
      h_nxt    = in_first_word ? (in_seed ^ in_total_len) : h_r;
      w_nxt    = in_data_word;
      nb_nxt   = in_nb_sat[1:0];
      last_nxt = in_last_word;
    end

    unique case (ctrl.op)
      ST_K1:   k_nxt = mul_p ^ (mul_p >> MIX_SHIFT);
      ST_K2:   k_nxt = mul_p;
      ST_HMIX: h_nxt = mul_p ^ k_r;
      ST_TAIL: h_nxt = mul_p;
      ST_AVAL: begin
        if (ctrl.aval_fire) begin
          h_nxt         = mul_p ^ (mul_p >> AVAL_SHIFT_B);
          out_hash_nxt  = mul_p ^ (mul_p >> AVAL_SHIFT_B);
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r         <= 32'd0;
      out_valid_r <= 1'b0;
      last_r      <= 1'b0;
    end else begin
      h_r         <= h_nxt;
      out_valid_r <= out_valid_nxt;
      last_r      <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    w_r        <= w_nxt;
    nb_r       <= nb_nxt;
    out_hash_r <= out_hash_nxt;
  end

  assign in_stall       = ~ctrl.ready;
  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

`include "murmur2_hash_engine_core_assert.svh"

  // never overwrite a result that is still held
  `MM2_ASSERT_NOW(a_no_overwrite, ctrl.aval_fire, !(out_valid_r && out_stall))
  // a plain word is back to ready after the K1, K2 and HMIX steps
  `MM2_ASSERT_NOW(a_word_cycles, ctrl.accept && !in_last_word, ##4 ctrl.ready)
  // a result only ever follows a last item
  `MM2_ASSERT_NEXT(a_result_last, ctrl.aval_fire, out_valid_r && last_r)

endmodule
